// ===== rtl/core/ncsi_pkg.sv =====
// Shared types, constants and saturation helpers for the natural cubic spline interpolator.
package ncsi_pkg;

  localparam int MAX_KNOTS      = 256;
  localparam int KNOT_AW        = $clog2(MAX_KNOTS);
  localparam int CNT_W          = KNOT_AW + 1;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = 48;
  localparam int MD_W           = 52;
  localparam int MD_PW          = 2 * MD_W;
  localparam int MD_CW          = $clog2(MD_PW);

  typedef logic [2:0] status_t;
  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_BELOW    = 3'd1;
  localparam status_t ST_ABOVE    = 3'd2;
  localparam status_t ST_FEW      = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;
  localparam status_t ST_NONINC   = 3'd5;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [MD_W-1:0]   md_t;

  typedef struct packed {
    logic signed [31:0] y;
    logic signed [31:0] x;
  } knot_word_t;

  typedef struct packed {
    coef_t u;
    coef_t z;
    coef_t b;
    coef_t c;
    coef_t d;
  } coef_word_t;

  localparam md_t ONE_F    = md_t'(64'd1 << COEF_FRAC_BITS);
  localparam md_t ONE_16   = md_t'(64'd1 << 16);
  localparam md_t THREE_16 = md_t'(64'd3 << 16);

  localparam md_t SAT_HI = {{(MD_W-COEF_W+1){1'b0}}, {(COEF_W-1){1'b1}}};
  localparam md_t SAT_LO = {{(MD_W-COEF_W+1){1'b1}}, {(COEF_W-1){1'b0}}};
  localparam md_t V32_HI = md_t'(64'sh7FFFFFFF);
  localparam md_t V32_LO = md_t'(-64'sh80000000);

  function automatic coef_t sat48(input md_t v);
    if (v > SAT_HI) return SAT_HI[COEF_W-1:0];
    if (v < SAT_LO) return SAT_LO[COEF_W-1:0];
    return v[COEF_W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input md_t v);
    if (v > V32_HI) return V32_HI[31:0];
    if (v < V32_LO) return V32_LO[31:0];
    return v[31:0];
  endfunction

endpackage

// ===== rtl/core/ncsi_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module ncsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/ncsi_muldiv.sv =====
// Bit-serial round(a*b/den) unit: shift-add multiply, restoring divide, round and saturate.
module ncsi_muldiv (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  ncsi_pkg::md_t a,
  input  ncsi_pkg::md_t b,
  input  ncsi_pkg::md_t den,
  output logic          done,
  output ncsi_pkg::coef_t result
);
  import ncsi_pkg::*;

  typedef enum logic [2:0] {MD_IDLE, MD_ABS, MD_MUL, MD_DIV, MD_FIN} md_state_t;

  md_state_t         state;
  md_t               ar, br;
  logic [MD_W-1:0]   dreg, mplier, rem, a_mag, b_mag;
  logic [MD_PW-1:0]  mcand, num;
  logic [MD_CW-1:0]  cnt;
  logic              neg, rem_ge, q_up;
  logic [MD_W:0]     rem_sh, rem_sub;
  logic [MD_PW:0]    q_rnd, q_lim;
  logic [COEF_W-1:0] q_sat;

  always_comb begin
    a_mag   = ar[MD_W-1] ? $unsigned(-ar) : $unsigned(ar);
    b_mag   = br[MD_W-1] ? $unsigned(-br) : $unsigned(br);
    rem_sh  = {rem, num[MD_PW-1]};
    rem_ge  = rem_sh >= {1'b0, dreg};
    rem_sub = rem_sh - {1'b0, dreg};
    q_up    = {rem, 1'b0} >= {1'b0, dreg};
    q_rnd   = {1'b0, num} + (MD_PW+1)'(q_up);
    q_lim   = neg ? ((MD_PW+1)'(1) << (COEF_W-1)) : (((MD_PW+1)'(1) << (COEF_W-1)) - 1'b1);
    q_sat   = (q_rnd > q_lim) ? q_lim[COEF_W-1:0] : q_rnd[COEF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (start) begin
            ar    <= a;
            br    <= b;
            dreg  <= den;
            state <= MD_ABS;
          end
        end
        MD_ABS: begin
          neg    <= ar[MD_W-1] ^ br[MD_W-1];
          mcand  <= {{MD_W{1'b0}}, a_mag};
          mplier <= b_mag;
          num    <= '0;
          cnt    <= '0;
          if (dreg == '0) begin
            dreg <= MD_W'(1);
          end
          state <= MD_MUL;
        end
        MD_MUL: begin
          if (mplier[0]) begin
            num <= num + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == MD_CW'(MD_W-1)) begin
            cnt   <= '0;
            rem   <= '0;
            state <= MD_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        MD_DIV: begin
          rem <= rem_ge ? rem_sub[MD_W-1:0] : rem_sh[MD_W-1:0];
          num <= {num[MD_PW-2:0], rem_ge};
          if (cnt == MD_CW'(MD_PW-1)) begin
            state <= MD_FIN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        MD_FIN: begin
          result <= neg ? (~q_sat + 1'b1) : q_sat;
          done   <= 1'b1;
          state  <= MD_IDLE;
        end
        default: state <= MD_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/natural_cubic_spline_interpolator.sv =====
// Top level: knot load, natural-spline solve and segment evaluation around two knot/coefficient RAMs.
// Load item without last: accepted, no result.
// Closing load item: result after a solve of 5 forward and 4 backward bit-serial mul/div
//   passes per knot, or with no solve when the load has a fault or fewer than two knots.
// Query item: a binary segment search plus 3 mul/div passes.
// One item at a time; a finished result waits in the output register while the next is taken.
// Synchronous active-high reset: no knots, status "too few knots", load closed, no result.
module natural_cubic_spline_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] x, [63:32] y
  input  logic        s_tuser,   // [0] func
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [2:0]  m_tuser,   // [2:0] status
  output logic        m_tlast    // batch_end
);
  import ncsi_pkg::*;

  typedef enum logic [5:0] {
    IDLE, EMIT,
    SRCH, SRCH_RD, SRCH_CMP, EV_RD, EV_LD, EV_GO, EV_WT,
    SF_RD0, SF_K0, SF_RD, SF_LD, SF_S_GO, SF_S_WT, SF_L_GO, SF_L_WT,
    SF_U_GO, SF_U_WT, SF_T_GO, SF_T_WT, SF_Z_GO, SF_Z_WT,
    BK_INIT, BK_RDM, BK_KM, BK_RD, BK_LD, BK_S_GO, BK_S_WT, BK_C_GO, BK_C_WT,
    BK_B_GO, BK_B_WT, BK_D_GO, BK_D_WT
  } state_t;

  state_t state;

  // load bookkeeping
  logic [CNT_W-1:0]   knot_count;
  status_t            solve_status, load_fault;
  logic               load_open;
  logic signed [31:0] first_x, prev_x;

  // memory ports
  logic [KNOT_AW-1:0] rd_addr;
  knot_word_t         k_rd, k_wdata;
  logic               knot_we;
  coef_word_t         c_rd, cwdata;
  logic               cwe;
  logic [KNOT_AW-1:0] cwaddr;

  // mul/div unit
  logic  md_start, md_done;
  md_t   md_a, md_b, md_den;
  coef_t md_res;

  // working registers
  logic signed [31:0] qx, px, py, ev_y;
  logic [KNOT_AW-1:0] lo, hi, mid, idx, last_idx, mid_c;
  logic signed [32:0] hprev, hcur, dy, ev_t;
  coef_t              sprev, scur, alpha, tt, u_new, u_prev, z_prev;
  coef_t              cu, cz, cn, cc, cb, acc, ev_b, ev_c;
  md_t                lden, l_calc;
  logic [1:0]         ev_step;

  // result holding register
  logic signed [31:0] res_value;
  status_t            res_status;
  logic               res_last;

  // load item decode
  logic signed [31:0] x_in, y_in;
  logic [CNT_W-1:0]   ld_cnt_base, ld_cnt_new;
  status_t            ld_fault_base, ld_fault_new;
  logic               ld_room, s_fire;

  assign x_in     = s_tdata[31:0];
  assign y_in     = s_tdata[63:32];
  assign s_tready = (state == IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign last_idx = KNOT_AW'(knot_count - 1'b1);
  assign mid_c    = KNOT_AW'((CNT_W'(lo) + CNT_W'(hi)) >> 1);

  always_comb begin
    // The first knot after a closed load starts a fresh table.
    ld_cnt_base   = load_open ? knot_count : '0;
    ld_fault_base = load_open ? load_fault : ST_OK;
    ld_room       = ld_cnt_base < CNT_W'(MAX_KNOTS);
    ld_cnt_new    = ld_room ? ld_cnt_base + 1'b1 : ld_cnt_base;
    ld_fault_new  = ld_fault_base;
    if (ld_fault_base == ST_OK) begin
      if (!ld_room) begin
        ld_fault_new = ST_OVERFLOW;
      end else if (ld_cnt_base != '0 && x_in <= prev_x) begin
        ld_fault_new = ST_NONINC;
      end
    end
    knot_we   = s_fire && (s_tuser == FUNC_LOAD) && ld_room;
    k_wdata.x = x_in;
    k_wdata.y = y_in;
    // Pivot l of the forward sweep, clamped to at least one.
    l_calc = ((md_t'(hprev) + md_t'(hcur)) <<< 1) - md_t'(md_res);
    if (l_calc < md_t'(1)) begin
      l_calc = md_t'(1);
    end
  end

  // Operand select for the shared mul/div unit.
  always_comb begin
    md_start = 1'b0;
    md_a     = md_t'(acc);
    md_b     = '0;
    md_den   = ONE_16;
    unique case (state)
      EV_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(acc);
        md_b     = md_t'(ev_t);
        md_den   = (ev_step == 2'd2) ? ONE_F : ONE_16;
      end
      SF_S_GO, BK_S_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(dy);
        md_b     = ONE_F;
        md_den   = md_t'(hcur);
      end
      SF_L_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(hprev);
        md_b     = md_t'(u_prev);
        md_den   = ONE_F;
      end
      SF_U_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(hcur);
        md_b     = ONE_F;
        md_den   = lden;
      end
      SF_T_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(hprev);
        md_b     = md_t'(z_prev);
        md_den   = ONE_16;
      end
      SF_Z_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(tt);
        md_b     = ONE_16;
        md_den   = lden;
      end
      BK_C_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(cu);
        md_b     = md_t'(cn);
        md_den   = ONE_F;
      end
      BK_B_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(hcur);
        md_b     = md_t'(cn) + (md_t'(cc) <<< 1);
        md_den   = THREE_16;
      end
      BK_D_GO: begin
        md_start = 1'b1;
        md_a     = md_t'(cn) - md_t'(cc);
        md_b     = ONE_16;
        md_den   = (md_t'(hcur) <<< 1) + md_t'(hcur);
      end
      default: begin
      end
    endcase
  end

  ncsi_ram #(.WIDTH($bits(knot_word_t)), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk   (clk),
    .we    (knot_we),
    .waddr (ld_cnt_base[KNOT_AW-1:0]),
    .wdata (k_wdata),
    .raddr (rd_addr),
    .rdata (k_rd)
  );

  ncsi_ram #(.WIDTH($bits(coef_word_t)), .DEPTH(MAX_KNOTS)) u_coef_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (cwdata),
    .raddr (rd_addr),
    .rdata (c_rd)
  );

  ncsi_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .a      (md_a),
    .b      (md_b),
    .den    (md_den),
    .done   (md_done),
    .result (md_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      knot_count   <= '0;
      solve_status <= ST_FEW;
      load_open    <= 1'b0;
      load_fault   <= ST_OK;
      m_tvalid     <= 1'b0;
      cwe          <= 1'b0;
    end else begin
      cwe <= 1'b0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_fire) begin
            res_value <= '0;
            res_last  <= s_tlast;
            if (s_tuser == FUNC_LOAD) begin
              load_open    <= 1'b1;
              knot_count   <= ld_cnt_new;
              load_fault   <= ld_fault_new;
              solve_status <= ST_FEW;
              if (ld_room) begin
                prev_x <= x_in;
                if (ld_cnt_base == '0) begin
                  first_x <= x_in;
                end
              end
              if (s_tlast) begin
                load_open <= 1'b0;
                if (ld_fault_new != ST_OK) begin
                  solve_status <= ld_fault_new;
                  res_status   <= ld_fault_new;
                  state        <= EMIT;
                end else if (ld_cnt_new < CNT_W'(2)) begin
                  res_status <= ST_FEW;
                  state      <= EMIT;
                end else begin
                  rd_addr <= '0;
                  state   <= SF_RD0;
                end
              end
            end else begin
              qx <= x_in;
              if (solve_status != ST_OK) begin
                res_status <= solve_status;
                state      <= EMIT;
              end else if (x_in < first_x) begin
                res_status <= ST_BELOW;
                state      <= EMIT;
              end else if (x_in > prev_x) begin
                res_status <= ST_ABOVE;
                state      <= EMIT;
              end else begin
                lo    <= '0;
                hi    <= KNOT_AW'(knot_count - CNT_W'(2));
                state <= SRCH;
              end
            end
          end
        end
        EMIT: begin
          // Hand over once the output register is free.
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res_value;
            m_tuser  <= res_status;
            m_tlast  <= res_last;
            state    <= IDLE;
          end
        end
        // Binary search for the lowest segment whose upper knot is not below x.
        SRCH: begin
          if (lo < hi) begin
            mid     <= mid_c;
            rd_addr <= mid_c + 1'b1;
            state   <= SRCH_RD;
          end else begin
            rd_addr <= lo;
            state   <= EV_RD;
          end
        end
        SRCH_RD: state <= SRCH_CMP;
        SRCH_CMP: begin
          if (qx <= k_rd.x) begin
            hi <= mid;
          end else begin
            lo <= mid + 1'b1;
          end
          state <= SRCH;
        end
        // Horner evaluation: d, then c, then b, then y.
        EV_RD: state <= EV_LD;
        EV_LD: begin
          ev_t    <= 33'(qx) - 33'(k_rd.x);
          ev_y    <= k_rd.y;
          ev_b    <= c_rd.b;
          ev_c    <= c_rd.c;
          acc     <= c_rd.d;
          ev_step <= 2'd0;
          state   <= EV_GO;
        end
        EV_GO: state <= EV_WT;
        EV_WT: begin
          if (md_done) begin
            if (ev_step == 2'd0) begin
              acc     <= sat48(md_t'(ev_c) + md_t'(md_res));
              ev_step <= 2'd1;
              state   <= EV_GO;
            end else if (ev_step == 2'd1) begin
              acc     <= sat48(md_t'(ev_b) + md_t'(md_res));
              ev_step <= 2'd2;
              state   <= EV_GO;
            end else begin
              res_value  <= sat32(md_t'(ev_y) + md_t'(md_res));
              res_status <= ST_OK;
              state      <= EMIT;
            end
          end
        end
        // Forward sweep: u and z per interior knot, carried in registers.
        SF_RD0: state <= SF_K0;
        SF_K0: begin
          px      <= k_rd.x;
          py      <= k_rd.y;
          idx     <= '0;
          rd_addr <= KNOT_AW'(1);
          state   <= SF_RD;
        end
        SF_RD: state <= SF_LD;
        SF_LD: begin
          hcur  <= 33'(k_rd.x) - 33'(px);
          dy    <= 33'(k_rd.y) - 33'(py);
          px    <= k_rd.x;
          py    <= k_rd.y;
          state <= SF_S_GO;
        end
        SF_S_GO: state <= SF_S_WT;
        SF_S_WT: begin
          if (md_done) begin
            if (idx == '0) begin
              sprev  <= md_res;
              hprev  <= hcur;
              u_prev <= '0;
              z_prev <= '0;
              cwe    <= 1'b1;
              cwaddr <= '0;
              cwdata <= '0;
              idx    <= KNOT_AW'(1);
              if (last_idx == KNOT_AW'(1)) begin
                state <= BK_INIT;
              end else begin
                rd_addr <= KNOT_AW'(2);
                state   <= SF_RD;
              end
            end else begin
              scur  <= md_res;
              alpha <= sat48(((md_t'(md_res) - md_t'(sprev)) <<< 1) +
                             (md_t'(md_res) - md_t'(sprev)));
              state <= SF_L_GO;
            end
          end
        end
        SF_L_GO: state <= SF_L_WT;
        SF_L_WT: begin
          if (md_done) begin
            lden  <= l_calc;
            state <= SF_U_GO;
          end
        end
        SF_U_GO: state <= SF_U_WT;
        SF_U_WT: begin
          if (md_done) begin
            u_new <= md_res;
            state <= SF_T_GO;
          end
        end
        SF_T_GO: state <= SF_T_WT;
        SF_T_WT: begin
          if (md_done) begin
            tt    <= sat48(md_t'(alpha) - md_t'(md_res));
            state <= SF_Z_GO;
          end
        end
        SF_Z_GO: state <= SF_Z_WT;
        SF_Z_WT: begin
          if (md_done) begin
            cwe      <= 1'b1;
            cwaddr   <= idx;
            cwdata   <= '0;
            cwdata.u <= u_new;
            cwdata.z <= md_res;
            u_prev   <= u_new;
            z_prev   <= md_res;
            hprev    <= hcur;
            sprev    <= scur;
            if (CNT_W'(idx) + 1'b1 < CNT_W'(last_idx)) begin
              idx     <= idx + 1'b1;
              rd_addr <= idx + KNOT_AW'(2);
              state   <= SF_RD;
            end else begin
              state <= BK_INIT;
            end
          end
        end
        // Back substitution from the last knot down; c of segment j+1 rides in cn.
        BK_INIT: begin
          cwe     <= 1'b1;
          cwaddr  <= last_idx;
          cwdata  <= '0;
          rd_addr <= last_idx;
          state   <= BK_RDM;
        end
        BK_RDM: state <= BK_KM;
        BK_KM: begin
          px      <= k_rd.x;
          py      <= k_rd.y;
          cn      <= '0;
          idx     <= last_idx - 1'b1;
          rd_addr <= last_idx - 1'b1;
          state   <= BK_RD;
        end
        BK_RD: state <= BK_LD;
        BK_LD: begin
          hcur  <= 33'(px) - 33'(k_rd.x);
          dy    <= 33'(py) - 33'(k_rd.y);
          px    <= k_rd.x;
          py    <= k_rd.y;
          cu    <= c_rd.u;
          cz    <= c_rd.z;
          state <= BK_S_GO;
        end
        BK_S_GO: state <= BK_S_WT;
        BK_S_WT: begin
          if (md_done) begin
            scur  <= md_res;
            state <= BK_C_GO;
          end
        end
        BK_C_GO: state <= BK_C_WT;
        BK_C_WT: begin
          if (md_done) begin
            cc    <= sat48(md_t'(cz) - md_t'(md_res));
            state <= BK_B_GO;
          end
        end
        BK_B_GO: state <= BK_B_WT;
        BK_B_WT: begin
          if (md_done) begin
            cb    <= sat48(md_t'(scur) - md_t'(md_res));
            state <= BK_D_GO;
          end
        end
        BK_D_GO: state <= BK_D_WT;
        BK_D_WT: begin
          if (md_done) begin
            cwe      <= 1'b1;
            cwaddr   <= idx;
            cwdata.u <= cu;
            cwdata.z <= cz;
            cwdata.b <= cb;
            cwdata.c <= cc;
            cwdata.d <= md_res;
            cn       <= cc;
            if (idx == '0) begin
              solve_status <= ST_OK;
              res_status   <= ST_OK;
              state        <= EMIT;
            end else begin
              idx     <= idx - 1'b1;
              rd_addr <= idx - 1'b1;
              state   <= BK_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/ncsi_checker.sv =====
// Port-level checker for the spline interpolator, bound to the top level.
module ncsi_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);
  import ncsi_pkg::*;

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("stalled result changed");

  // Status stays within the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BELOW || m_tuser == ST_ABOVE ||
                  m_tuser == ST_FEW || m_tuser == ST_OVERFLOW || m_tuser == ST_NONINC))
    else $error("status out of range");

  // Any fault result carries a zero value.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == 32'd0)
    else $error("nonzero value with fault status");

endmodule

bind natural_cubic_spline_interpolator ncsi_checker u_ncsi_checker (.*);
